[hdl/hrfp_pkg.sv]
// Shared types, constants and helpers for the HEX record parser.
`timescale 1ns / 1ps

package hrfp_pkg;

    localparam int unsigned POS_W              = 7;
    localparam int unsigned MAX_LINE_CHARS_DEF = 64;
    localparam int unsigned FIFO_DEPTH         = 2;

    localparam logic [7:0]       ASCII_NL      = 8'h0A;
    localparam logic [POS_W-1:0] DATA_START    = POS_W'(9);
    localparam logic [POS_W-1:0] ADDR_FIRST    = POS_W'(3);
    localparam logic [POS_W-1:0] TYPE_FIRST    = POS_W'(7);
    // start mark, count, address, type and checksum characters
    localparam logic [9:0]       LINE_OVERHEAD = 10'd11;

    localparam logic [7:0] TYPE_DATA       = 8'h00;
    localparam logic [7:0] TYPE_EOF        = 8'h01;
    localparam logic [7:0] TYPE_EXT_LINEAR = 8'h04;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic {
        RK_WRITE  = 1'b0,
        RK_FINISH = 1'b1
    } t_result_kind;

    typedef struct packed {
        logic             is_nl;
        logic             overlong;
        logic [POS_W-1:0] pos;
        logic             hex_ok;
        logic [3:0]       digit;
    } t_token;

    typedef struct packed {
        t_result_kind result_kind;
        logic [31:0]  write_address;
        logic [15:0]  write_halfword;
        logic [7:0]   record_type;
        t_status      record_status;
        logic         send_ack;
        logic         end_of_file;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Upper-case hex digits only.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

[hdl/hrfp_if.sv]
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps

interface hrfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface hrfp_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] write_address;
    logic [15:0] write_halfword;
    logic [7:0]  record_type;
    logic [1:0]  record_status;
    logic        send_ack;
    logic        end_of_file;

    modport source (
        output valid, input ready,
        output result_kind, output write_address, output write_halfword,
        output record_type, output record_status, output send_ack,
        output end_of_file
    );
    modport sink (
        input valid, output ready,
        input result_kind, input write_address, input write_halfword,
        input record_type, input record_status, input send_ack,
        input end_of_file
    );
endinterface

[hdl/hrfp_front.sv]
// Front end: takes characters, tracks line position and classifies each beat.
`timescale 1ns / 1ps

module hrfp_front #(
    parameter int unsigned MAX_LINE_CHARS = hrfp_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hrfp_in_if.sink          i_rx,
    input  logic             i_full,
    output logic             o_push,
    output hrfp_pkg::t_token o_token
);

    localparam logic [hrfp_pkg::POS_W-1:0] MaxPos = hrfp_pkg::POS_W'(MAX_LINE_CHARS);

    logic [hrfp_pkg::POS_W-1:0] r_pos;
    logic [hrfp_pkg::POS_W-1:0] n_pos;
    hrfp_pkg::t_hex             hex;

    assign i_rx.ready = !i_full;
    assign o_push     = i_rx.valid && !i_full;
    assign hex        = hrfp_pkg::hex_decode(i_rx.rx_char);

    always_comb begin
        o_token.is_nl    = (i_rx.rx_char == hrfp_pkg::ASCII_NL);
        o_token.overlong = (r_pos >= MaxPos);
        o_token.pos      = r_pos;
        o_token.hex_ok   = hex.ok;
        o_token.digit    = hex.val;

        n_pos = r_pos;
        if (o_push) begin
            if (o_token.is_nl) begin
                n_pos = '0;
            end else if (!o_token.overlong) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[hdl/hrfp_fifo.sv]
// Short queue of classified beats between front and back ends.
`timescale 1ns / 1ps

module hrfp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrfp_pkg::t_token i_data,
    output logic             o_full,
    input  logic             i_pop,
    output hrfp_pkg::t_token o_data,
    output logic             o_empty
);

    localparam int unsigned PtrW = $clog2(hrfp_pkg::FIFO_DEPTH);
    localparam int unsigned CntW = $clog2(hrfp_pkg::FIFO_DEPTH + 1);

    hrfp_pkg::t_token r_mem [hrfp_pkg::FIFO_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    assign o_full  = (r_count == CntW'(hrfp_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(hrfp_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(hrfp_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/hrfp_back.sv]
// Back end: record decoding, halfword writes and the result register.
`timescale 1ns / 1ps

module hrfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrfp_pkg::t_token i_token,
    input  logic             i_empty,
    output logic             o_pop,
    hrfp_out_if.source       o_res
);

    logic [15:0]                r_digit_shift, n_digit_shift;
    logic [7:0]                 r_count, n_count;
    logic [7:0]                 r_type, n_type;
    logic [15:0]                r_upper, n_upper;
    logic [15:0]                r_lower, n_lower;
    logic [6:0]                 r_hw_index, n_hw_index;
    hrfp_pkg::t_status          r_line_error, n_line_error;
    logic                       r_stopped, n_stopped;
    logic                       r_out_valid, n_out_valid;
    hrfp_pkg::t_result          r_out, n_out;

    logic [15:0]                shift_next;
    logic [hrfp_pkg::POS_W-1:0] k;
    logic [8:0]                 ndig;
    logic                       complete;
    logic                       good;
    logic [31:0]                addr;

    assign o_pop = !i_empty && (!r_out_valid || o_res.ready);

    always_comb begin
        n_digit_shift = r_digit_shift;
        n_count       = r_count;
        n_type        = r_type;
        n_upper       = r_upper;
        n_lower       = r_lower;
        n_hw_index    = r_hw_index;
        n_line_error  = r_line_error;
        n_stopped     = r_stopped;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out         = r_out;

        shift_next = {r_digit_shift[11:0], i_token.digit};
        k          = i_token.pos - hrfp_pkg::DATA_START;
        ndig       = {r_count, 1'b0};
        complete   = ({3'b000, i_token.pos} >= ({1'b0, ndig} + hrfp_pkg::LINE_OVERHEAD));
        good       = (r_line_error == hrfp_pkg::ST_OK) && complete;
        addr       = {r_upper, r_lower} + {24'h0, r_hw_index, 1'b0};

        if (o_pop && !r_stopped) begin
            if (i_token.is_nl) begin
                n_out_valid            = 1'b1;
                n_out.result_kind      = hrfp_pkg::RK_FINISH;
                n_out.write_address    = '0;
                n_out.write_halfword   = '0;
                n_out.record_type      = r_type;
                n_out.record_status    = r_line_error;
                n_out.send_ack         = good && (r_type == hrfp_pkg::TYPE_DATA);
                n_out.end_of_file      = good && (r_type == hrfp_pkg::TYPE_EOF);
                n_stopped              = good && (r_type == hrfp_pkg::TYPE_EOF);
                n_digit_shift          = '0;
                n_count                = '0;
                n_type                 = '0;
                n_hw_index             = '0;
                n_line_error           = hrfp_pkg::ST_OK;
            end else if (i_token.overlong) begin
                if (r_line_error == hrfp_pkg::ST_OK) begin
                    n_line_error = hrfp_pkg::ST_TOO_LONG;
                end
            end else if (i_token.pos != '0 && r_line_error == hrfp_pkg::ST_OK) begin
                if (!i_token.hex_ok) begin
                    n_line_error = hrfp_pkg::ST_BAD_DIGIT;
                end else if (i_token.pos < hrfp_pkg::ADDR_FIRST) begin
                    n_count = {r_count[3:0], i_token.digit};
                end else if (i_token.pos < hrfp_pkg::TYPE_FIRST) begin
                    n_lower = {r_lower[11:0], i_token.digit};
                end else if (i_token.pos < hrfp_pkg::DATA_START) begin
                    n_type = {r_type[3:0], i_token.digit};
                end else begin
                    n_digit_shift = shift_next;
                    if (r_type == hrfp_pkg::TYPE_EXT_LINEAR && k == 7'd3) begin
                        n_upper = shift_next;
                    end else if (r_type == hrfp_pkg::TYPE_DATA && {2'b00, k} < ndig) begin
                        // full halfword on every fourth digit, padded one on an odd last byte
                        if (k[1:0] == 2'd3 ||
                            (k[1:0] == 2'd1 && ({2'b00, k} + 9'd1) == ndig)) begin
                            n_out_valid          = 1'b1;
                            n_out.result_kind    = hrfp_pkg::RK_WRITE;
                            n_out.write_address  = addr;
                            n_out.write_halfword = (k[1:0] == 2'd3) ? shift_next
                                                                    : {shift_next[7:0], 8'h00};
                            n_out.record_type    = '0;
                            n_out.record_status  = hrfp_pkg::ST_OK;
                            n_out.send_ack       = 1'b0;
                            n_out.end_of_file    = 1'b0;
                            n_hw_index           = r_hw_index + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_shift <= '0;
            r_count       <= '0;
            r_type        <= '0;
            r_upper       <= '0;
            r_lower       <= '0;
            r_hw_index    <= '0;
            r_line_error  <= hrfp_pkg::ST_OK;
            r_stopped     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_digit_shift <= n_digit_shift;
            r_count       <= n_count;
            r_type        <= n_type;
            r_upper       <= n_upper;
            r_lower       <= n_lower;
            r_hw_index    <= n_hw_index;
            r_line_error  <= n_line_error;
            r_stopped     <= n_stopped;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_out.result_kind;
    assign o_res.write_address  = r_out.write_address;
    assign o_res.write_halfword = r_out.write_halfword;
    assign o_res.record_type    = r_out.record_type;
    assign o_res.record_status  = r_out.record_status;
    assign o_res.send_ack       = r_out.send_ack;
    assign o_res.end_of_file    = r_out.end_of_file;

endmodule

[hdl/hex_record_flash_parser.sv]
// Top level of the Intel HEX record parser.
`timescale 1ns / 1ps

// Takes one ASCII character a beat on i_rx and gives halfword write beats and
// record-finished beats on o_res. One character is taken every clock cycle while
// the queue is not full; a result passes through the two-entry queue behind the
// position tracker and then the decoder's result register. Either side may stall
// on its own. Only upper-case hex digits are accepted, the checksum is not
// verified, and after an end-of-file record all input is swallowed until reset.
// No clearing pass is needed after reset.
module hex_record_flash_parser #(
    parameter int unsigned MAX_LINE_CHARS = hrfp_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrfp_in_if.sink     i_rx,
    hrfp_out_if.source  o_res
);

    hrfp_pkg::t_token push_token;
    hrfp_pkg::t_token pop_token;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    hrfp_front #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (full),
        .o_push  (push),
        .o_token (push_token)
    );

    hrfp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_token),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_token),
        .o_empty (empty)
    );

    hrfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_token (pop_token),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
